/* rtl/relative_strength_index_assert.svh */
// assertion macros used by the checker file of the rsi block
// no dependencies
`ifndef RELATIVE_STRENGTH_INDEX_ASSERT_SVH
`define RELATIVE_STRENGTH_INDEX_ASSERT_SVH

// general property check on a clock with a synchronous reset
`define RSI_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// a stalled word stays offered and unchanged
`define RSI_ASSERT_HOLD(label, clk, rst, vld, rdy, data) \
   label: assert property (@(posedge clk) disable iff (rst) vld && !rdy |=> vld && $stable(data)) \
      else $error("word changed or dropped while stalled");

`endif

/* rtl/rsi_pkg.sv */
// shared types and constants of the relative strength index block
// no dependencies
package rsi_pkg;

   localparam int MAX_WINDOW_DEF    = 64;
   localparam int SAMPLE_BITS_DEF   = 32;
   localparam int DIGIT_BITS        = 8;
   localparam int SAMPLE_FIELD_BITS = 32;
   localparam int TAG_BITS          = 32;
   localparam int WINDOW_BITS       = 7;
   localparam int RSI_BITS          = 15;
   localparam int CSR_ADDR_BITS     = 3;
   localparam int CSR_DATA_BITS     = 32;

   localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 7'd14;
   localparam logic [RSI_BITS-1:0]    RSI_SCALE      = 15'd25600;
   localparam logic [RSI_BITS-1:0]    RSI_FLAT_VALUE = 15'd12800;

   localparam logic [CSR_ADDR_BITS-3:0] REG_WINDOW_LENGTH = 1'b0;

   typedef struct packed {
      logic [SAMPLE_FIELD_BITS-1:0] sample_value;
      logic [TAG_BITS-1:0]          sample_tag;
      logic                         series_start;
   } req_word_type;

   typedef struct packed {
      logic [RSI_BITS-1:0] rsi_value;
      logic [TAG_BITS-1:0] result_tag;
      logic                flat_window;
   } rsp_word_type;

   typedef struct packed {
      logic start;
      logic clear;
   } acc_ctrl_type;

   typedef struct packed {
      logic done;
      logic zero;
   } acc_stat_type;

endpackage

/* rtl/rsi_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
module rsi_ram #(
   parameter int DATA_BITS = 33,
   parameter int DEPTH     = 64,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem_ff [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/rsi_accum.sv */
// digit-serial update of the gain and loss sums and of their total
// depends on rsi_pkg
module rsi_accum
   import rsi_pkg::*;
#(
   parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   localparam int SUM_BITS   = SAMPLE_BITS + $clog2(MAX_WINDOW)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  acc_ctrl_type           acc_ctrl,
   input  logic                   new_fall,
   input  logic [SAMPLE_BITS-1:0] new_mag,
   input  logic                   old_fall,
   input  logic [SAMPLE_BITS-1:0] old_mag,
   input  logic                   remove_old,
   output acc_stat_type           acc_stat,
   output logic [SUM_BITS-1:0]    gain_sum,
   output logic [SUM_BITS-1:0]    total_sum
);

   localparam int NDIG      = (SUM_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
   localparam int PAD_BITS  = NDIG * DIGIT_BITS;
   localparam int CNT_BITS  = $clog2(NDIG);

   logic [PAD_BITS-1:0]     gain_ff, loss_ff, tot_ff;
   logic [PAD_BITS-1:0]     gadd_ff, gsub_ff, ladd_ff, lsub_ff;
   logic [PAD_BITS-1:0]     new_ext, old_ext;
   logic signed [1:0]       gc_ff, lc_ff;
   logic                    tc_ff, zero_ff, busy_ff, done_ff;
   logic [CNT_BITS-1:0]     cnt_ff;
   logic signed [DIGIT_BITS+1:0] gdig, ldig;
   logic [DIGIT_BITS:0]     tdig;

   assign new_ext = PAD_BITS'(new_mag);
   assign old_ext = PAD_BITS'(old_mag);

   always_comb begin
      gdig = $signed({2'b00, gain_ff[DIGIT_BITS-1:0]})
           + $signed({2'b00, gadd_ff[DIGIT_BITS-1:0]})
           - $signed({2'b00, gsub_ff[DIGIT_BITS-1:0]})
           + $signed({{DIGIT_BITS{gc_ff[1]}}, gc_ff});
      ldig = $signed({2'b00, loss_ff[DIGIT_BITS-1:0]})
           + $signed({2'b00, ladd_ff[DIGIT_BITS-1:0]})
           - $signed({2'b00, lsub_ff[DIGIT_BITS-1:0]})
           + $signed({{DIGIT_BITS{lc_ff[1]}}, lc_ff});
      tdig = {1'b0, gdig[DIGIT_BITS-1:0]} + {1'b0, ldig[DIGIT_BITS-1:0]}
           + {{DIGIT_BITS{1'b0}}, tc_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= '0;
         loss_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (acc_ctrl.clear) begin
            gain_ff <= '0;
            loss_ff <= '0;
         end else if (acc_ctrl.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            gain_ff <= {gdig[DIGIT_BITS-1:0], gain_ff[PAD_BITS-1:DIGIT_BITS]};
            loss_ff <= {ldig[DIGIT_BITS-1:0], loss_ff[PAD_BITS-1:DIGIT_BITS]};
            if (cnt_ff == CNT_BITS'(NDIG - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff + 1'b1;
            end
         end
      end
   end

   // operand digits and carries
   always_ff @(posedge clock) begin
      if (acc_ctrl.start) begin
         gadd_ff <= new_fall ? '0 : new_ext;
         ladd_ff <= new_fall ? new_ext : '0;
         gsub_ff <= (remove_old && !old_fall) ? old_ext : '0;
         lsub_ff <= (remove_old && old_fall) ? old_ext : '0;
         gc_ff   <= '0;
         lc_ff   <= '0;
         tc_ff   <= 1'b0;
         zero_ff <= 1'b1;
      end else if (busy_ff) begin
         gadd_ff <= gadd_ff >> DIGIT_BITS;
         ladd_ff <= ladd_ff >> DIGIT_BITS;
         gsub_ff <= gsub_ff >> DIGIT_BITS;
         lsub_ff <= lsub_ff >> DIGIT_BITS;
         gc_ff   <= gdig[DIGIT_BITS+1:DIGIT_BITS];
         lc_ff   <= ldig[DIGIT_BITS+1:DIGIT_BITS];
         tc_ff   <= tdig[DIGIT_BITS];
         tot_ff  <= {tdig[DIGIT_BITS-1:0], tot_ff[PAD_BITS-1:DIGIT_BITS]};
         zero_ff <= zero_ff & (tdig[DIGIT_BITS-1:0] == '0);
      end
   end

   assign gain_sum      = gain_ff[SUM_BITS-1:0];
   assign total_sum     = tot_ff[SUM_BITS-1:0];
   assign acc_stat.done = done_ff;
   assign acc_stat.zero = zero_ff;

endmodule

/* rtl/rsi_div.sv */
// restoring divider giving floor(25600 * gain / total), one quotient bit per step
// depends on rsi_pkg
module rsi_div
   import rsi_pkg::*;
#(
   parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   localparam int SUM_BITS   = SAMPLE_BITS + $clog2(MAX_WINDOW)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [SUM_BITS-1:0] gain_sum,
   input  logic [SUM_BITS-1:0] total_sum,
   output logic                done,
   output logic [RSI_BITS-1:0] quotient
);

   localparam int REM_BITS = SUM_BITS + 1;
   localparam int IDX_BITS = $clog2(RSI_BITS);

   logic [REM_BITS-1:0] rem_ff;
   logic [SUM_BITS-1:0] gain_ff, total_ff;
   logic [REM_BITS:0]   gmt_ff;
   logic [RSI_BITS-1:0] q_ff;
   logic [IDX_BITS-1:0] idx_ff;
   logic                busy_ff, add_phase_ff, done_ff;

   logic [REM_BITS-1:0] rem_dbl, rem_add;
   logic [REM_BITS:0]   try_dbl, try_add;
   logic                ok_dbl, ok_add, last_step;

   always_comb begin
      rem_dbl   = {rem_ff[REM_BITS-2:0], 1'b0};
      try_dbl   = {1'b0, rem_dbl} - {2'b00, total_ff};
      ok_dbl    = !try_dbl[REM_BITS];
      rem_add   = rem_ff + {1'b0, gain_ff};
      try_add   = {1'b0, rem_ff} + gmt_ff;
      ok_add    = !try_add[REM_BITS];
      last_step = (idx_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         add_phase_ff <= 1'b0;
         done_ff      <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff      <= 1'b1;
            add_phase_ff <= 1'b0;
         end else if (busy_ff) begin
            if (!add_phase_ff && RSI_SCALE[idx_ff]) begin
               add_phase_ff <= 1'b1;
            end else begin
               add_phase_ff <= 1'b0;
               if (last_step) begin
                  busy_ff <= 1'b0;
                  done_ff <= 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         gain_ff  <= gain_sum;
         total_ff <= total_sum;
         gmt_ff   <= {2'b00, gain_sum} - {2'b00, total_sum};
         rem_ff   <= '0;
         q_ff     <= '0;
         idx_ff   <= IDX_BITS'(RSI_BITS - 1);
      end else if (busy_ff) begin
         if (!add_phase_ff) begin
            rem_ff <= ok_dbl ? try_dbl[REM_BITS-1:0] : rem_dbl;
            q_ff   <= {q_ff[RSI_BITS-2:0], ok_dbl};
            if (!RSI_SCALE[idx_ff] && !last_step) begin
               idx_ff <= idx_ff - 1'b1;
            end
         end else begin
            rem_ff <= ok_add ? try_add[REM_BITS-1:0] : rem_add;
            q_ff   <= q_ff + RSI_BITS'(ok_add);
            if (!last_step) begin
               idx_ff <= idx_ff - 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

/* rtl/relative_strength_index.sv */
// Relative strength index over a sliding window of sample differences.
// Each accepted word carries one sample; from sample p+1 of a series on,
// with p the window_length held to 1..MAX_WINDOW, every sample yields one
// result word with rsi_value = floor(25600*G/(G+L)) in Q7.8 percent, or
// 50 percent with flat_window set when both sums are zero. An item that
// gives a value passes through the digit-serial sum update, eight bits a
// cycle, and the eighteen steps of the restoring divider; a warm-up item
// takes only the sum update, a flat result skips the divider, and the
// first sample of a series is only stored. A new sample is taken once the
// last is through. Writing window_length restarts the series. Depends on
// rsi_pkg, rsi_ram, rsi_accum and rsi_div.
module relative_strength_index
   import rsi_pkg::*;
#(
   parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_word_type             req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_word_type             rsp_data,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   localparam int SUM_BITS   = SAMPLE_BITS + $clog2(MAX_WINDOW);
   localparam int PTR_BITS   = $clog2(MAX_WINDOW);
   localparam int SEEN_BITS  = $clog2(MAX_WINDOW + 2);
   localparam int EXT_BITS   = (SAMPLE_BITS > SAMPLE_FIELD_BITS) ? SAMPLE_BITS
                                                                  : SAMPLE_FIELD_BITS;
   localparam int ENTRY_BITS = SAMPLE_BITS + 1;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_READ = 5'b00010,
      ST_ACC  = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

   state_type              state_ff, state_in;
   logic [WINDOW_BITS-1:0] window_ff;
   logic [SEEN_BITS-1:0]   seen_ff, seen_eff, p_eff;
   logic [PTR_BITS-1:0]    ptr_ff, ptr_eff, ptr_use, ptr_next, addr_ff;
   logic [SEEN_BITS-1:0]   ptr_inc;
   logic [SAMPLE_BITS-1:0] prev_ff, sample, dmag_ff, diff_mag;
   logic [EXT_BITS-1:0]    sample_ext;
   logic [SAMPLE_BITS:0]   up_diff, down_diff;
   logic                   dfall_ff, remove_ff, produce_ff;
   logic [TAG_BITS-1:0]    tag_ff;
   logic [RSI_BITS-1:0]    res_value_ff, quotient;
   logic                   res_flat_ff;
   rsp_word_type           rsp_word_ff;
   logic                   rsp_valid_ff;
   logic                   accept, cfg_wr, out_free, load_out, div_start, div_done;
   logic [ENTRY_BITS-1:0]  old_entry;
   logic [SUM_BITS-1:0]    gain_sum, total_sum;
   acc_ctrl_type           acc_ctrl;
   acc_stat_type           acc_stat;

   // configuration port
   assign cfg_wr     = csr_psel & csr_penable & csr_pwrite
                     & (csr_paddr[CSR_ADDR_BITS-1:2] == REG_WINDOW_LENGTH);
   assign csr_prdata = CSR_DATA_BITS'(window_ff);
   assign csr_pready = 1'b1;

   always_comb begin
      if (window_ff == '0) begin
         p_eff = SEEN_BITS'(1);
      end else if (32'(window_ff) > 32'(MAX_WINDOW)) begin
         p_eff = SEEN_BITS'(MAX_WINDOW);
      end else begin
         p_eff = SEEN_BITS'(window_ff);
      end
   end

   assign accept     = req_valid & req_ready;
   assign req_ready  = (state_ff == ST_IDLE);
   assign sample_ext = EXT_BITS'(req_data.sample_value);
   assign sample     = sample_ext[SAMPLE_BITS-1:0];

   always_comb begin
      up_diff   = {1'b0, sample} - {1'b0, prev_ff};
      down_diff = {1'b0, prev_ff} - {1'b0, sample};
      diff_mag  = up_diff[SAMPLE_BITS] ? down_diff[SAMPLE_BITS-1:0]
                                       : up_diff[SAMPLE_BITS-1:0];
      seen_eff  = req_data.series_start ? '0 : seen_ff;
      ptr_eff   = req_data.series_start ? '0 : ptr_ff;
      ptr_use   = (SEEN_BITS'(ptr_eff) >= p_eff) ? '0 : ptr_eff;
      ptr_inc   = SEEN_BITS'(ptr_use) + SEEN_BITS'(1);
      ptr_next  = (ptr_inc >= p_eff) ? '0 : ptr_inc[PTR_BITS-1:0];
   end

   assign out_free  = !rsp_valid_ff | rsp_ready;
   assign load_out  = (state_ff == ST_OUT) & out_free;
   assign div_start = (state_ff == ST_ACC) & acc_stat.done & produce_ff & !acc_stat.zero;

   assign acc_ctrl.start = (state_ff == ST_READ);
   assign acc_ctrl.clear = cfg_wr | (accept & req_data.series_start);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && seen_eff != '0) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (acc_stat.done) begin
               if (!produce_ff) begin
                  state_in = ST_IDLE;
               end else if (acc_stat.zero) begin
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         window_ff    <= WINDOW_RESET;
         seen_ff      <= '0;
         ptr_ff       <= '0;
         prev_ff      <= '0;
         remove_ff    <= 1'b0;
         produce_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cfg_wr) begin
            window_ff <= csr_pwdata[WINDOW_BITS-1:0];
            seen_ff   <= '0;
            ptr_ff    <= '0;
            prev_ff   <= '0;
         end else if (accept) begin
            prev_ff <= sample;
            if (seen_eff == '0) begin
               seen_ff <= SEEN_BITS'(1);
               ptr_ff  <= '0;
            end else begin
               ptr_ff     <= ptr_next;
               remove_ff  <= (seen_eff > p_eff);
               produce_ff <= (seen_eff >= p_eff);
               if (seen_eff <= p_eff) begin
                  seen_ff <= seen_eff + SEEN_BITS'(1);
               end else begin
                  seen_ff <= seen_eff;
               end
            end
         end
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         tag_ff   <= req_data.sample_tag;
         addr_ff  <= ptr_use;
         dfall_ff <= up_diff[SAMPLE_BITS];
         dmag_ff  <= diff_mag;
      end
      if (state_ff == ST_ACC && acc_stat.done && acc_stat.zero) begin
         res_value_ff <= RSI_FLAT_VALUE;
         res_flat_ff  <= 1'b1;
      end else if (state_ff == ST_DIV && div_done) begin
         res_value_ff <= quotient;
         res_flat_ff  <= 1'b0;
      end
      if (load_out) begin
         rsp_word_ff.rsi_value   <= res_value_ff;
         rsp_word_ff.result_tag  <= tag_ff;
         rsp_word_ff.flat_window <= res_flat_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_word_ff;

   rsi_ram #(
      .DATA_BITS (ENTRY_BITS),
      .DEPTH     (MAX_WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (state_ff == ST_READ),
      .wr_addr (addr_ff),
      .wr_data ({dfall_ff, dmag_ff}),
      .rd_en   (accept),
      .rd_addr (ptr_use),
      .rd_data (old_entry)
   );

   rsi_accum #(
      .MAX_WINDOW  (MAX_WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_accum (
      .clock      (clock),
      .reset      (reset),
      .acc_ctrl   (acc_ctrl),
      .new_fall   (dfall_ff),
      .new_mag    (dmag_ff),
      .old_fall   (old_entry[SAMPLE_BITS]),
      .old_mag    (old_entry[SAMPLE_BITS-1:0]),
      .remove_old (remove_ff),
      .acc_stat   (acc_stat),
      .gain_sum   (gain_sum),
      .total_sum  (total_sum)
   );

   rsi_div #(
      .MAX_WINDOW  (MAX_WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .gain_sum  (gain_sum),
      .total_sum (total_sum),
      .done      (div_done),
      .quotient  (quotient)
   );

endmodule

/* rtl/rsi_checker.sv */
// port-level checks of the relative strength index block, bound to the top level
// depends on rsi_pkg and relative_strength_index_assert.svh
`include "relative_strength_index_assert.svh"

module rsi_checker
   import rsi_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input rsp_word_type             rsp_data,
   input logic                     csr_psel,
   input logic                     csr_penable,
   input logic                     csr_pwrite,
   input logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input logic [CSR_DATA_BITS-1:0] csr_pwdata,
   input logic [CSR_DATA_BITS-1:0] csr_prdata
);

   `RSI_ASSERT_HOLD(rsp_word_held, clock, reset, rsp_valid, rsp_ready, rsp_data)

   `RSI_ASSERT(rsi_in_range, clock, reset, rsp_valid |-> rsp_data.rsi_value <= RSI_SCALE, "rsi value above full scale")

   `RSI_ASSERT(flat_gives_half, clock, reset, rsp_valid && rsp_data.flat_window |-> rsp_data.rsi_value == RSI_FLAT_VALUE, "flat window without half scale")

   `RSI_ASSERT(window_reads_back, clock, reset, csr_psel && csr_penable && csr_pwrite && csr_paddr[CSR_ADDR_BITS-1:2] == REG_WINDOW_LENGTH |=> csr_prdata[WINDOW_BITS-1:0] == $past(csr_pwdata[WINDOW_BITS-1:0]), "window length not taken")

   `RSI_ASSERT(no_instant_result, clock, reset, req_valid && req_ready |=> !$rose(rsp_valid), "result straight after a sample")

endmodule

bind relative_strength_index rsi_checker u_rsi_checker (.*);

/* dv/tb.sv */
`timescale 1ns / 1ps
// testbench for relative_strength_index: random and directed price words over several
// window lengths, checked word by word against an in-bench rsi predictor
// depends on rsi_pkg and the relative_strength_index rtl
module tb;
   import rsi_pkg::*;

   localparam int LIMIT_CYCLES = 800000;
   localparam int SETTLE_CYCLES = 64;
   localparam logic [CSR_ADDR_BITS-1:0] WINDOW_ADDR = {REG_WINDOW_LENGTH, 2'b00};

   class rsi_ledger;
      logic [WINDOW_BITS-1:0] window_length;
      logic signed [32:0]     diff_ring [MAX_WINDOW_DEF];
      int unsigned            ring_ptr;
      int unsigned            seen;
      logic [37:0]            gains;
      logic [37:0]            losses;
      logic [31:0]            prev;
      rsp_word_type           pending_rsi [$];
      int                     mismatches;

      function new();
         window_length = WINDOW_RESET;
         mismatches = 0;
         clear();
      endfunction

      function void clear();
         ring_ptr = 0;
         seen = 0;
         gains = '0;
         losses = '0;
         prev = '0;
      endfunction

      function void set_window(logic [WINDOW_BITS-1:0] v);
         window_length = v;
         clear();
      endfunction

      function int unsigned span();
         if (window_length < 1) return 1;
         if (window_length > MAX_WINDOW_DEF) return MAX_WINDOW_DEF;
         return 32'(window_length);
      endfunction

      function void take_sample(req_word_type w);
         int unsigned  p;
         longint       d;
         longint       old;
         logic [38:0]  total;
         logic [63:0]  scaled;
         rsp_word_type r;
         p = span();
         if (w.series_start) clear();
         if (seen == 0) begin
            prev = w.sample_value;
            seen = 1;
            return;
         end
         if (ring_ptr >= p) ring_ptr = 0;
         if (seen > p) begin
            old = longint'(diff_ring[ring_ptr]);
            if (old > 0) gains = gains - 38'(old);
            else if (old < 0) losses = losses - 38'(-old);
         end
         d = longint'(w.sample_value) - longint'(prev);
         if (d > 0) gains = gains + 38'(d);
         else if (d < 0) losses = losses + 38'(-d);
         diff_ring[ring_ptr] = 33'(d);
         ring_ptr = (ring_ptr + 1 >= p) ? 0 : ring_ptr + 1;
         prev = w.sample_value;
         if (seen <= p) seen++;
         if (seen <= p) return;
         total = {1'b0, gains} + {1'b0, losses};
         if (total == 0) begin
            r.rsi_value = RSI_FLAT_VALUE;
            r.flat_window = 1'b1;
         end else begin
            scaled = (64'(gains) * 64'(RSI_SCALE)) / 64'(total);
            r.rsi_value = scaled[RSI_BITS-1:0];
            r.flat_window = 1'b0;
         end
         r.result_tag = w.sample_tag;
         pending_rsi.push_back(r);
      endfunction

      function void match_result(rsp_word_type r);
         rsp_word_type e;
         if (pending_rsi.size() == 0) begin
            $display("%0t unexpected result word: expected none, got %h", $time, r);
            mismatches++;
            return;
         end
         e = pending_rsi.pop_front();
         if (r.rsi_value !== e.rsi_value) begin
            $display("%0t rsi_value: expected %0d, got %0d", $time, e.rsi_value, r.rsi_value);
            mismatches++;
         end
         if (r.result_tag !== e.result_tag) begin
            $display("%0t result_tag: expected %h, got %h", $time, e.result_tag, r.result_tag);
            mismatches++;
         end
         if (r.flat_window !== e.flat_window) begin
            $display("%0t flat_window: expected %b, got %b", $time, e.flat_window,
                     r.flat_window);
            mismatches++;
         end
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid;
   logic                     req_ready;
   req_word_type             req_data;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   rsp_word_type             rsp_data;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   rsi_ledger   ledger;
   int          burst_left = 0;
   int          cycle_count = 0;
   int          rsp_phase = 0;
   int          stall_left = 0;
   logic [31:0] walk_value = '0;

   relative_strength_index dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // receiver: free running, coin-toss stalls, then long stall stretches
   always @(posedge clock) begin
      rsp_phase <= rsp_phase + 1;
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         case ((rsp_phase / 300) % 3)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            default: begin
               if ($urandom_range(0, 7) == 0) begin
                  stall_left <= $urandom_range(5, 30);
                  rsp_ready <= 1'b0;
               end else begin
                  rsp_ready <= 1'b1;
               end
            end
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) ledger.match_result(rsp_data);
   end

   task automatic csr_access(input logic wr, input logic [CSR_DATA_BITS-1:0] wdata,
                             output logic [CSR_DATA_BITS-1:0] rdata);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= WINDOW_ADDR;
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_window(input logic [WINDOW_BITS-1:0] v);
      logic [CSR_DATA_BITS-1:0] rd;
      csr_access(1'b1, CSR_DATA_BITS'(v), rd);
      ledger.set_window(v);
      csr_access(1'b0, '0, rd);
      if (rd[WINDOW_BITS-1:0] !== v) begin
         $display("%0t window_length readback: expected %0d, got %0d", $time, v,
                  rd[WINDOW_BITS-1:0]);
         ledger.mismatches++;
      end
   endtask

   // sender: bursts of words separated by random gaps
   task automatic push_sample(input logic [31:0] v, input logic [31:0] t, input logic st);
      req_word_type w;
      int           gap;
      w.sample_value = v;
      w.sample_tag = t;
      w.series_start = st;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
         burst_left = $urandom_range(1, 40);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (!req_ready);
      ledger.take_sample(w);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (ledger.pending_rsi.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [31:0] walk_sample(logic [31:0] cur);
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 65) return cur + 32'($urandom_range(0, 2000)) - 32'd1000;
      if (pick < 80) return cur;
      if (pick < 92) return $urandom;
      return pick[0] ? 32'hFFFF_FFFF : 32'h0;
   endfunction

   task automatic run_random(input int n);
      for (int i = 0; i < n; i++) begin
         walk_value = walk_sample(walk_value);
         push_sample(walk_value, $urandom, $urandom_range(0, 99) < 2);
      end
   endtask

   initial begin
      logic [WINDOW_BITS-1:0] windows [8];
      ledger = new();
      req_valid <= 1'b0;
      req_data <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_window(7'd3);
      // full-scale swings
      push_sample(32'h0, 32'h0, 1'b1);
      push_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      push_sample(32'h0, 32'h1, 1'b0);
      push_sample(32'hFFFF_FFFF, 32'h2, 1'b0);
      push_sample(32'h0, 32'h3, 1'b0);
      // flat window
      push_sample(32'd5, 32'h10, 1'b1);
      push_sample(32'd5, 32'h11, 1'b0);
      push_sample(32'd5, 32'h12, 1'b0);
      push_sample(32'd5, 32'h13, 1'b0);
      // gains only, then losses only
      push_sample(32'd6, 32'h20, 1'b0);
      push_sample(32'd7, 32'h21, 1'b0);
      push_sample(32'd8, 32'h22, 1'b0);
      push_sample(32'd7, 32'h30, 1'b0);
      push_sample(32'd6, 32'h31, 1'b0);
      push_sample(32'd5, 32'h32, 1'b0);
      // restart in the middle of warm-up
      push_sample(32'd100, 32'h40, 1'b1);
      push_sample(32'd90, 32'h41, 1'b0);
      push_sample(32'd200, 32'h42, 1'b1);
      push_sample(32'd201, 32'h43, 1'b0);
      push_sample(32'd199, 32'h44, 1'b0);
      push_sample(32'd203, 32'h45, 1'b0);
      push_sample(32'd202, 32'hAAAA_5555, 1'b0);
      drain_results();

      windows = '{7'd0, 7'd1, 7'd64, 7'd127, 7'd14, 7'd2, 7'd0, 7'd0};
      windows[6] = 7'($urandom_range(1, 64));
      windows[7] = 7'($urandom_range(0, 127));
      foreach (windows[k]) begin
         write_window(windows[k]);
         run_random(240);
         drain_results();
      end

      if (ledger.mismatches == 0 && ledger.pending_rsi.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
